FILE: hw/rtl/ngd_pkg.sv
// Shared constants and types for the next-greater-distance block.
package ngd_pkg;

  localparam int MAX_LEN_DEF     = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SAMPLE_IN_W     = 16;
  localparam int SAMPLE_BITS_MAX = 32;
  localparam int POS_W           = 6;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_CLEAR
  } stack_op_t;

endpackage

FILE: hw/rtl/ngd_ram.sv
// Generic simple dual-port RAM with registered read.
module ngd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ngd_cell.sv
// One stack cell: holds a value and its index, shifts with its neighbours.
module ngd_cell #(
  parameter int SAMPLE_BITS = ngd_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W       = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ngd_pkg::stack_op_t            op,
  input  logic                          up_valid,
  input  logic signed [SAMPLE_BITS-1:0] up_value,
  input  logic [IDX_W-1:0]              up_index,
  input  logic                          down_valid,
  input  logic signed [SAMPLE_BITS-1:0] down_value,
  input  logic [IDX_W-1:0]              down_index,
  output logic                          valid,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic [IDX_W-1:0]              index
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        ngd_pkg::OP_PUSH:  valid <= up_valid;
        ngd_pkg::OP_POP:   valid <= down_valid;
        ngd_pkg::OP_CLEAR: valid <= 1'b0;
        default:           valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      ngd_pkg::OP_PUSH: begin
        value <= up_value;
        index <= up_index;
      end
      ngd_pkg::OP_POP: begin
        value <= down_value;
        index <= down_index;
      end
      default: begin
        value <= value;
        index <= index;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ngd_stack.sv
// Monotonic index stack built as a shifting row of cells, top at the first cell.
module ngd_stack #(
  parameter int DEPTH       = ngd_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_BITS = ngd_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W       = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ngd_pkg::stack_op_t            op,
  input  logic signed [SAMPLE_BITS-1:0] push_value,
  input  logic [IDX_W-1:0]              push_index,
  output logic                          top_valid,
  output logic signed [SAMPLE_BITS-1:0] top_value,
  output logic [IDX_W-1:0]              top_index
);

  logic                          st_valid [DEPTH+2];
  logic signed [SAMPLE_BITS-1:0] st_value [DEPTH+2];
  logic [IDX_W-1:0]              st_index [DEPTH+2];

  assign st_valid[0]       = 1'b1;
  assign st_value[0]       = push_value;
  assign st_index[0]       = push_index;
  assign st_valid[DEPTH+1] = 1'b0;
  assign st_value[DEPTH+1] = '0;
  assign st_index[DEPTH+1] = '0;

  for (genvar k = 1; k <= DEPTH; k++) begin : g_cell
    ngd_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .up_valid   (st_valid[k-1]),
      .up_value   (st_value[k-1]),
      .up_index   (st_index[k-1]),
      .down_valid (st_valid[k+1]),
      .down_value (st_value[k+1]),
      .down_index (st_index[k+1]),
      .valid      (st_valid[k]),
      .value      (st_value[k]),
      .index      (st_index[k])
    );
  end

  assign top_valid = st_valid[1];
  assign top_value = st_value[1];
  assign top_index = st_index[1];

endmodule

FILE: hw/rtl/next_greater_distance.sv
// Top level: loads a sample sequence, scans it with a cell-chain stack, emits distances.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_ready, sample, last_item          | into block
//   out     | out_valid, out_ready, position, distance,      | out of block
//           | final_result, overflowed                       |
//
// Loading accepts one item per cycle. On the item marked last the scan runs right to left:
// each position is read from the sample store, then compared with the top of the
// cell-chain stack, repeating the compare after each pop; each index is popped at most once.
// Emission reads each result from the distance store through its registered read, then
// loads it into the output register, which waits out any output stall.
// Reset clears the sequencer, the counters and the cell valid bits; stores need no clearing.
// The output register holds a result until taken; loading of the next sequence may proceed.
module next_greater_distance #(
  parameter int MAX_LEN     = ngd_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_BITS = ngd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ngd_pkg::SAMPLE_IN_W-1:0] sample,
  input  logic                            last_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ngd_pkg::POS_W-1:0]       position,
  output logic [ngd_pkg::POS_W-1:0]       distance,
  output logic                            final_result,
  output logic                            overflowed
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  ngd_pkg::state_t    state, state_next;
  ngd_pkg::stack_op_t stack_op;

  logic [CNT_W-1:0] count, count_next, count_after;
  logic             ovf, ovf_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             in_accept, room, pop, load_out, is_final;

  logic [ngd_pkg::SAMPLE_BITS_MAX-1:0] sample_wide;
  logic signed [SAMPLE_BITS-1:0]       sample_ext, cur;
  logic [ngd_pkg::POS_W-1:0]           dist_wdata, dist_rdata;

  logic                          top_valid;
  logic signed [SAMPLE_BITS-1:0] top_value;
  logic [IDX_W-1:0]              top_index;

  assign sample_wide = ngd_pkg::SAMPLE_BITS_MAX'(sample);
  assign sample_ext  = sample_wide[SAMPLE_BITS-1:0];

  assign in_ready    = (state == ngd_pkg::ST_LOAD);
  assign in_accept   = in_valid && in_ready;
  assign room        = (count < CNT_W'(MAX_LEN));
  assign count_after = room ? count + CNT_W'(1) : count;
  assign pop         = (state == ngd_pkg::ST_SCAN_CMP) && top_valid && (top_value <= cur);
  assign dist_wdata  = top_valid ? ngd_pkg::POS_W'(top_index - idx) : '0;
  assign is_final    = (CNT_W'(idx) == count - CNT_W'(1));

  ngd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LEN)
  ) u_sample_ram (
    .clk   (clk),
    .we    (in_accept && room),
    .waddr (count[IDX_W-1:0]),
    .wdata (sample_ext),
    .raddr (idx),
    .rdata (cur)
  );

  ngd_ram #(
    .WIDTH (ngd_pkg::POS_W),
    .DEPTH (MAX_LEN)
  ) u_dist_ram (
    .clk   (clk),
    .we    ((state == ngd_pkg::ST_SCAN_CMP) && !pop),
    .waddr (idx),
    .wdata (dist_wdata),
    .raddr (idx),
    .rdata (dist_rdata)
  );

  ngd_stack #(
    .DEPTH       (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_W       (IDX_W)
  ) u_stack (
    .clk        (clk),
    .rst        (rst),
    .op         (stack_op),
    .push_value (cur),
    .push_index (idx),
    .top_valid  (top_valid),
    .top_value  (top_value),
    .top_index  (top_index)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    idx_next   = idx;
    stack_op   = ngd_pkg::OP_HOLD;
    load_out   = 1'b0;
    case (state)
      ngd_pkg::ST_LOAD: begin
        if (in_accept) begin
          count_next = count_after;
          if (!room) begin
            ovf_next = 1'b1;
          end
          if (last_item) begin
            stack_op   = ngd_pkg::OP_CLEAR;
            idx_next   = IDX_W'(count_after - CNT_W'(1));
            state_next = ngd_pkg::ST_SCAN_RD;
          end
        end
      end
      ngd_pkg::ST_SCAN_RD: begin
        state_next = ngd_pkg::ST_SCAN_CMP;
      end
      ngd_pkg::ST_SCAN_CMP: begin
        if (pop) begin
          stack_op = ngd_pkg::OP_POP;
        end else begin
          stack_op = ngd_pkg::OP_PUSH;
          if (idx == '0) begin
            state_next = ngd_pkg::ST_EMIT_RD;
          end else begin
            idx_next   = idx - IDX_W'(1);
            state_next = ngd_pkg::ST_SCAN_RD;
          end
        end
      end
      ngd_pkg::ST_EMIT_RD: begin
        state_next = ngd_pkg::ST_EMIT_OUT;
      end
      ngd_pkg::ST_EMIT_OUT: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          if (is_final) begin
            count_next = '0;
            ovf_next   = 1'b0;
            idx_next   = '0;
            state_next = ngd_pkg::ST_LOAD;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = ngd_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ngd_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ngd_pkg::ST_LOAD;
      count <= '0;
      ovf   <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      position     <= ngd_pkg::POS_W'(idx);
      distance     <= dist_rdata;
      final_result <= is_final;
      overflowed   <= ovf;
    end
  end

endmodule
